// ----- hdl/tvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared constants and register codes for the trilinear voxel sampler.
// ----------------------------------------------------------------------------
package tvs_pkg;

	// default geometry and number format
	localparam int DIM_BITS_DEF   = 6;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int VOXEL_BITS_DEF = 16;

	// fixed port widths
	localparam int DIM_W   = 7;
	localparam int COORD_W = 6;
	localparam int VALUE_W = 16;
	localparam int POS_W   = 14;
	localparam int OUT_W   = 24;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIM_X = 2'd0,
		CFG_DIM_Y = 2'd1,
		CFG_DIM_Z = 2'd2
	} cfg_reg_t;

	// item modes
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

endpackage

// ----- hdl/tvs_voxel_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_voxel_ram
// Single-port voxel store with registered read.
// ----------------------------------------------------------------------------
module tvs_voxel_ram #(
	parameter int ADDR_BITS = 18,
	parameter int DATA_BITS = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [DATA_BITS-1:0] wdata,
	output logic [DATA_BITS-1:0] rdata
);
	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
	logic [DATA_BITS-1:0] rdata_q;

	// write on enable, read otherwise
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- hdl/tvs_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_mac
// Weighted corner accumulate: voxel times z weight, times xy weight, sum,
// then round and saturate after the last corner.
// ----------------------------------------------------------------------------
module tvs_mac #(
	parameter int FRAC_BITS  = 8,
	parameter int VOXEL_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       beat_valid,
	input  logic                       beat_last,
	input  logic [VOXEL_BITS-1:0]      voxel,
	input  logic [2*FRAC_BITS+1:0]     w_xy,
	input  logic [FRAC_BITS:0]         w_z,
	output logic                       done,
	output logic [tvs_pkg::OUT_W-1:0]  sample_value
);
	import tvs_pkg::*;

	localparam int VZ_W  = VOXEL_BITS + FRAC_BITS + 1;
	localparam int PW    = VZ_W + 2*FRAC_BITS + 2;
	localparam int SH_W  = PW - 2*FRAC_BITS;
	localparam logic [PW-1:0] HALF = PW'(1) << (2*FRAC_BITS - 1);
	localparam logic [SH_W-1:0] OUT_MAX = SH_W'({OUT_W{1'b1}});

	logic [VZ_W-1:0]        vz_s2;
	logic [2*FRAC_BITS+1:0] wxy_s2;
	logic                   v_s2, last_s2;
	logic [PW-1:0]          prod_s3;
	logic                   v_s3, last_s3;
	logic [PW-1:0]          acc_q;
	logic [PW-1:0]          total;
	logic [SH_W-1:0]        shifted;
	logic                   done_q;
	logic [OUT_W-1:0]       sample_q;

	// valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s2 <= beat_valid;
			v_s3 <= v_s2;
			done_q <= v_s3 && last_s3;
		end
	end

	// multiply stages
	always_ff @(posedge clk) begin
		vz_s2   <= VZ_W'(voxel) * VZ_W'(w_z);
		wxy_s2  <= w_xy;
		last_s2 <= beat_last;
		prod_s3 <= PW'(vz_s2) * PW'(wxy_s2);
		last_s3 <= last_s2;
	end

	// round half up, drop the extra fraction bits
	assign total   = acc_q + prod_s3;
	assign shifted = SH_W'((total + HALF) >> (2*FRAC_BITS));

	// accumulate; restart after the last corner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= last_s3 ? '0 : total;
		end
	end

	// saturate and hold the result
	always_ff @(posedge clk) begin
		if (v_s3 && last_s3) begin
			sample_q <= (shifted > OUT_MAX) ? {OUT_W{1'b1}} : OUT_W'(shifted);
		end
	end

	assign done = done_q;
	assign sample_value = sample_q;
endmodule

// ----- hdl/trilinear_voxel_sampler_top.sv -----
`timescale 1ns / 1ps
// A sample keeps busy high until its result beat raises done, so a new item is
// taken only after the last result has left; eight corner reads go one per cycle
// through the single voxel memory port. A write is taken while idle, and writes
// may follow back to back. No receiver stall.
// Reset: arst_n clears control and sets all dims to 64; the voxel store is
// not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// trilinear_voxel_sampler_top
// Voxel store with trilinear sampling over eight sequential corner reads.
// ----------------------------------------------------------------------------
module trilinear_voxel_sampler_top #(
	parameter int DIM_BITS   = tvs_pkg::DIM_BITS_DEF,
	parameter int FRAC_BITS  = tvs_pkg::FRAC_BITS_DEF,
	parameter int VOXEL_BITS = tvs_pkg::VOXEL_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [tvs_pkg::COORD_W-1:0]   vox_x,
	input  logic [tvs_pkg::COORD_W-1:0]   vox_y,
	input  logic [tvs_pkg::COORD_W-1:0]   vox_z,
	input  logic [tvs_pkg::VALUE_W-1:0]   vox_value,
	input  logic [tvs_pkg::POS_W-1:0]     pos_x,
	input  logic [tvs_pkg::POS_W-1:0]     pos_y,
	input  logic [tvs_pkg::POS_W-1:0]     pos_z,
	input  logic                          cfg_we,
	input  logic [tvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tvs_pkg::DIM_W-1:0]     cfg_data,
	output logic                          done,
	output logic [tvs_pkg::OUT_W-1:0]     sample_value
);
	import tvs_pkg::*;

	localparam int ADDR_BITS = 3*DIM_BITS;

	logic [DIM_W-1:0] dim_x_q, dim_y_q, dim_z_q;
	logic             busy_q, issue_q;
	logic [2:0]       cnt_q;
	logic [DIM_BITS-1:0] ix_q [2];
	logic [DIM_BITS-1:0] iy_q [2];
	logic [DIM_BITS-1:0] iz_q [2];
	logic [FRAC_BITS:0]  wx_q [2];
	logic [FRAC_BITS:0]  wy_q [2];
	logic [FRAC_BITS:0]  wz_q [2];
	logic [2*FRAC_BITS+1:0] wxy_s1;
	logic [FRAC_BITS:0]     wz_s1;
	logic                   v_s1, last_s1;
	logic                   accept, wr_en;
	logic [ADDR_BITS-1:0]   addr;
	logic [VOXEL_BITS-1:0]  rdata;
	logic                   mac_done;

	// clamp one corner index to [1, min(dim, side) - 1]
	function automatic logic [DIM_BITS-1:0] clamp_idx(input int idx, input int dim);
		int lim;
		int c;
		lim = (dim > (1 << DIM_BITS)) ? (1 << DIM_BITS) : dim;
		c = (idx > lim - 1) ? lim - 1 : idx;
		if (c < 1) c = 1;
		return DIM_BITS'(c);
	endfunction

	function automatic logic [FRAC_BITS-1:0] frac_of(input logic [POS_W-1:0] p);
		return p[FRAC_BITS-1:0];
	endfunction

	function automatic int whole_of(input logic [POS_W-1:0] p);
		return int'(p[POS_W-1:FRAC_BITS]);
	endfunction

	function automatic int upper_of(input logic [POS_W-1:0] p);
		return int'(p[POS_W-1:FRAC_BITS]) + ((p[FRAC_BITS-1:0] != '0) ? 1 : 0);
	endfunction

	assign accept = start && !busy_q;
	assign wr_en  = accept && (mode == MODE_WRITE);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= DIM_W'(64);
			dim_y_q <= DIM_W'(64);
			dim_z_q <= DIM_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIM_X: dim_x_q <= cfg_data;
				CFG_DIM_Y: dim_y_q <= cfg_data;
				CFG_DIM_Z: dim_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture corner indexes and weights of a sample
	always_ff @(posedge clk) begin
		if (accept && mode == MODE_SAMPLE) begin
			ix_q[0] <= clamp_idx(whole_of(pos_x), int'(dim_x_q));
			ix_q[1] <= clamp_idx(upper_of(pos_x), int'(dim_x_q));
			iy_q[0] <= clamp_idx(whole_of(pos_y), int'(dim_y_q));
			iy_q[1] <= clamp_idx(upper_of(pos_y), int'(dim_y_q));
			iz_q[0] <= clamp_idx(whole_of(pos_z), int'(dim_z_q));
			iz_q[1] <= clamp_idx(upper_of(pos_z), int'(dim_z_q));
			wx_q[0] <= (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(frac_of(pos_x));
			wx_q[1] <= (FRAC_BITS+1)'(frac_of(pos_x));
			wy_q[0] <= (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(frac_of(pos_y));
			wy_q[1] <= (FRAC_BITS+1)'(frac_of(pos_y));
			wz_q[0] <= (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(frac_of(pos_z));
			wz_q[1] <= (FRAC_BITS+1)'(frac_of(pos_z));
		end
	end

	// sequence the eight corner reads; busy until the result leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= 1'b0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
		end else begin
			v_s1 <= issue_q;
			if (accept && mode == MODE_SAMPLE) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				cnt_q   <= '0;
			end else begin
				if (issue_q) begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) issue_q <= 1'b0;
				end
				if (mac_done) busy_q <= 1'b0;
			end
		end
	end

	// corner weights travel with the read
	always_ff @(posedge clk) begin
		wxy_s1  <= (2*FRAC_BITS+2)'(wx_q[cnt_q[0]]) * (2*FRAC_BITS+2)'(wy_q[cnt_q[1]]);
		wz_s1   <= wz_q[cnt_q[2]];
		last_s1 <= (cnt_q == 3'd7);
	end

	// memory address: write address when idle, corner address otherwise
	assign addr = busy_q
		? {iz_q[cnt_q[2]], iy_q[cnt_q[1]], ix_q[cnt_q[0]]}
		: {DIM_BITS'(vox_z), DIM_BITS'(vox_y), DIM_BITS'(vox_x)};

	tvs_voxel_ram #(
		.ADDR_BITS(ADDR_BITS),
		.DATA_BITS(VOXEL_BITS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.addr (addr),
		.wdata(vox_value[VOXEL_BITS-1:0]),
		.rdata(rdata)
	);

	tvs_mac #(
		.FRAC_BITS (FRAC_BITS),
		.VOXEL_BITS(VOXEL_BITS)
	) u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat_valid  (v_s1),
		.beat_last   (last_s1),
		.voxel       (rdata),
		.w_xy        (wxy_s1),
		.w_z         (wz_s1),
		.done        (mac_done),
		.sample_value(sample_value)
	);

	assign busy = busy_q;
	assign done = mac_done;
endmodule

// ----- hdl/tvs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvs_checker
// Port-level checks of the sampler handshake and result timing.
// ----------------------------------------------------------------------------
module tvs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic mode,
	input logic done
);
	import tvs_pkg::*;

	// a sample beat makes the block busy
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_SAMPLE) |=> busy)
		else $error("sample accepted without busy");

	// a write beat leaves the block free
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_WRITE) |=> !busy)
		else $error("write made the block busy");

	// a result only ends a busy period
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a pending sample");

	// busy drops right after the result strobe
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

	// one strobe per sample
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");
endmodule

bind trilinear_voxel_sampler_top tvs_checker u_tvs_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.mode  (mode),
	.done  (done)
);

// ----- dv/trilinear_voxel_sampler_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_voxel_sampler_top_tb
// Self-checking bench: voxel writes and trilinear samples are driven through
// the start/busy port under several volume sizes. A scoreboard keeps its own
// copy of the volume, predicts each interpolated value and checks each done
// beat in order.
// ----------------------------------------------------------------------------
module trilinear_voxel_sampler_top_tb;
	import tvs_pkg::*;

	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int SIDE           = 1 << DIM_BITS_DEF;
	localparam int SETTLE_CYCLES  = 24;
	localparam longint CYCLE_LIMIT = 2000000;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// ------------------------------------------------------------------------
	// Volume model and expected-value store
	// ------------------------------------------------------------------------
	class voxel_scoreboard;
		bit [VALUE_W-1:0] volume [int];
		bit [DIM_W-1:0]   dims [3];
		bit [OUT_W-1:0]   pending_samples [$];
		int               mismatches;

		function void reset_dims();
			dims[0] = 64; dims[1] = 64; dims[2] = 64;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [DIM_W-1:0] val);
			if (idx < 3)
				dims[idx] = val;
		endfunction

		function int vox_addr(int x, int y, int z);
			return (z << (2 * DIM_BITS_DEF)) | (y << DIM_BITS_DEF) | x;
		endfunction

		// clamp a corner index into [1, min(dim, side) - 1], lower bound wins
		function int clamp_corner(int idx, int axis);
			int lim;
			int c;
			lim = (dims[axis] > SIDE) ? SIDE : int'(dims[axis]);
			c = idx;
			if (c > lim - 1)
				c = lim - 1;
			if (c < 1)
				c = 1;
			return c;
		endfunction

		// lower corner in [0], upper corner in [1]
		function void axis_corners(bit [POS_W-1:0] p, int axis, output int c [2]);
			int whole;
			int frac;
			whole = int'(p) >> FRAC;
			frac = int'(p) & ((1 << FRAC) - 1);
			c[0] = clamp_corner(whole, axis);
			c[1] = clamp_corner(whole + (frac != 0), axis);
		endfunction

		function bit is_written(int x, int y, int z);
			return volume.exists(vox_addr(x, y, z));
		endfunction

		// note one accepted beat; a sample pushes its interpolated value
		function void note_item(bit m, bit [COORD_W-1:0] vx, bit [COORD_W-1:0] vy,
				bit [COORD_W-1:0] vz, bit [VALUE_W-1:0] val,
				bit [POS_W-1:0] px, bit [POS_W-1:0] py, bit [POS_W-1:0] pz);
			int cx [2];
			int cy [2];
			int cz [2];
			longint unsigned wx [2];
			longint unsigned wy [2];
			longint unsigned wz [2];
			longint unsigned acc;
			longint unsigned rounded;
			if (m == MODE_WRITE) begin
				volume[vox_addr(vx, vy, vz)] = val;
				return;
			end
			axis_corners(px, 0, cx);
			axis_corners(py, 1, cy);
			axis_corners(pz, 2, cz);
			wx[1] = px & ((1 << FRAC) - 1); wx[0] = (1 << FRAC) - wx[1];
			wy[1] = py & ((1 << FRAC) - 1); wy[0] = (1 << FRAC) - wy[1];
			wz[1] = pz & ((1 << FRAC) - 1); wz[0] = (1 << FRAC) - wz[1];
			acc = 0;
			for (int k = 0; k < 2; k++)
				for (int j = 0; j < 2; j++)
					for (int i = 0; i < 2; i++)
						acc += longint'(volume[vox_addr(cx[i], cy[j], cz[k])])
							* wx[i] * wy[j] * wz[k];
			rounded = (acc + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
			if (rounded > 64'hFF_FFFF)
				rounded = 64'hFF_FFFF;
			pending_samples.push_back(rounded[OUT_W-1:0]);
		endfunction

		function void check_sample(bit [OUT_W-1:0] got);
			bit [OUT_W-1:0] want;
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected done beat: sample_value=%0d", got);
				return;
			end
			want = pending_samples.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("sample_value mismatch: expected %0d, actual %0d", want, got);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 mode;
	logic [COORD_W-1:0]   vox_x, vox_y, vox_z;
	logic [VALUE_W-1:0]   vox_value;
	logic [POS_W-1:0]     pos_x, pos_y, pos_z;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	logic                 done;
	logic [OUT_W-1:0]     sample_value;

	voxel_scoreboard sb;
	longint          cycle_count;

	trilinear_voxel_sampler_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.vox_x        (vox_x),
		.vox_y        (vox_y),
		.vox_z        (vox_z),
		.vox_value    (vox_value),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.sample_value (sample_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// check every done beat
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_sample(sample_value);
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// send one beat; returns at the accepting edge with start still high
	task automatic send_beat(bit m, bit [COORD_W-1:0] vx, bit [COORD_W-1:0] vy,
			bit [COORD_W-1:0] vz, bit [VALUE_W-1:0] val,
			bit [POS_W-1:0] px, bit [POS_W-1:0] py, bit [POS_W-1:0] pz);
		int gap;
		gap = $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		mode      <= m;
		vox_x     <= vx;
		vox_y     <= vy;
		vox_z     <= vz;
		vox_value <= val;
		pos_x     <= px;
		pos_y     <= py;
		pos_z     <= pz;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_item(m, vx, vy, vz, val, px, py, pz);
	endtask

	task automatic write_voxel(int x, int y, int z, bit [VALUE_W-1:0] val);
		send_beat(MODE_WRITE, COORD_W'(x), COORD_W'(y), COORD_W'(z), val,
			POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
	endtask

	// fill any unwritten corner first, then sample
	task automatic sample_at(bit [POS_W-1:0] px, bit [POS_W-1:0] py, bit [POS_W-1:0] pz);
		int cx [2];
		int cy [2];
		int cz [2];
		sb.axis_corners(px, 0, cx);
		sb.axis_corners(py, 1, cy);
		sb.axis_corners(pz, 2, cz);
		for (int k = 0; k < 2; k++)
			for (int j = 0; j < 2; j++)
				for (int i = 0; i < 2; i++)
					if (!sb.is_written(cx[i], cy[j], cz[k]))
						write_voxel(cx[i], cy[j], cz[k], VALUE_W'($urandom));
		send_beat(MODE_SAMPLE, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			VALUE_W'($urandom), px, py, pz);
	endtask

	// drain results, let the block settle, then write registers
	task automatic set_dims(bit [DIM_W-1:0] dx, bit [DIM_W-1:0] dy, bit [DIM_W-1:0] dz);
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_samples.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1; cfg_index <= CFG_DIM_X; cfg_data <= dx; @(posedge clk);
		sb.set_reg(CFG_DIM_X, dx);
		cfg_index <= CFG_DIM_Y; cfg_data <= dy; @(posedge clk);
		sb.set_reg(CFG_DIM_Y, dy);
		cfg_index <= CFG_DIM_Z; cfg_data <= dz; @(posedge clk);
		sb.set_reg(CFG_DIM_Z, dz);
		// unmapped index must leave the dims alone
		cfg_index <= CFG_UNUSED; cfg_data <= DIM_W'($urandom); @(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit [POS_W-1:0] pick_pos(int axis);
		int lim;
		int p;
		lim = (sb.dims[axis] > SIDE) ? SIDE : int'(sb.dims[axis]);
		case ($urandom_range(0, 9))
			0: begin
				p = $urandom_range(0, (1 << POS_W) - 1);
			end
			1: begin
				p = $urandom_range(0, lim + 1) << FRAC;
			end
			2: begin
				p = ($urandom_range(0, lim) << FRAC) | ((1 << FRAC) - 1);
			end
			default: begin
				p = $urandom_range(0, (lim + 1) * (1 << FRAC));
			end
		endcase
		if (p > (1 << POS_W) - 1)
			p = (1 << POS_W) - 1;
		return POS_W'(p);
	endfunction

	initial begin
		bit [DIM_W-1:0] dim_sets [6][3];
		sb = new();
		sb.reset_dims();
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0; mode = MODE_WRITE;
		vox_x = '0; vox_y = '0; vox_z = '0; vox_value = '0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		cfg_we = 1'b0; cfg_index = CFG_DIM_X; cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme values, positions at the ends, integral and half
		write_voxel(1, 1, 1, 16'hFFFF);
		write_voxel(2, 1, 1, 16'h0000);
		write_voxel(63, 63, 63, 16'hFFFF);
		write_voxel(0, 0, 0, 16'h1234);
		sample_at('0, '0, '0);
		sample_at(14'h3FFF, 14'h3FFF, 14'h3FFF);
		sample_at(POS_W'(1 << FRAC), POS_W'(1 << FRAC), POS_W'(1 << FRAC));
		sample_at(POS_W'((1 << FRAC) | 8'h80), POS_W'(1 << FRAC), POS_W'(1 << FRAC));
		sample_at(POS_W'((1 << FRAC) | 8'hFF), POS_W'((1 << FRAC) | 8'h01),
			POS_W'((2 << FRAC) | 8'h80));
		sample_at(POS_W'(63 << FRAC), POS_W'(62 << FRAC | 8'h40), 14'h3FFF);
		for (int i = 0; i < 6; i++)
			sample_at(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));

		// volume sizes: reset size, minimum, beyond the store, degenerate, odd
		dim_sets[0] = '{7'd2, 7'd2, 7'd2};
		dim_sets[1] = '{7'd127, 7'd100, 7'd65};
		dim_sets[2] = '{7'd0, 7'd1, 7'd5};
		dim_sets[3] = '{7'd17, 7'd33, 7'd9};
		dim_sets[4] = '{7'd64, 7'd64, 7'd64};
		dim_sets[5] = '{7'd3, 7'd64, 7'd2};

		// random: mostly samples over the volume, some stray writes
		for (int ph = 0; ph < 6; ph++) begin
			set_dims(dim_sets[ph][0], dim_sets[ph][1], dim_sets[ph][2]);
			for (int n = 0; n < 16; n++) begin
				if ($urandom_range(0, 4) == 0)
					write_voxel($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
						$urandom_range(0, SIDE - 1), VALUE_W'($urandom));
				else
					sample_at(pick_pos(0), pick_pos(1), pick_pos(2));
			end
		end

		// drain and settle
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
